// ===== hdl/sos_pkg.sv =====
// Shared types and codes for the set-of-stacks engine.
`default_nettype none

package sos_pkg;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_TOP    = 3'd2,
		OP_POP_AT = 3'd3,
		OP_EMPTYQ = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_CUR,
		S_PUSH_CHK,
		S_SCAN,
		S_RDATA,
		S_PAT,
		S_PAT_LOW
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/sos_cnt_file.sv =====
// Per-sub-stack entry counts with one shared read/write index.
`default_nettype none

module sos_cnt_file #(
	parameter int NUM_STACKS  = 8,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [$clog2(NUM_STACKS)-1:0]    idx,
	output logic      [$clog2(STACK_DEPTH+1)-1:0] rd_cnt,
	input  wire logic                             we,
	input  wire logic [$clog2(STACK_DEPTH+1)-1:0] wr_cnt
);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic [CNT_W-1:0] counts_q [NUM_STACKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (we) begin
			counts_q[idx] <= wr_cnt;
		end
	end

	assign rd_cnt = counts_q[idx];

endmodule

`default_nettype wire

// ===== hdl/sos_word_ram.sv =====
// Word store for all sub-stacks, one port, registered read.
`default_nettype none

module sos_word_ram #(
	parameter int ADDR_W     = 7,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic                  re,
	input  wire logic [ADDR_W-1:0]     addr,
	input  wire logic [DATA_WIDTH-1:0] wdata,
	output logic      [DATA_WIDTH-1:0] rdata
);
	logic [DATA_WIDTH-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sos_ctrl.sv =====
// Request sequencer: walks the count file one sub-stack per cycle.
`default_nettype none

module sos_ctrl #(
	parameter int NUM_STACKS  = 8,
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [2:0]                            op,
	input  wire logic signed [31:0]                    value,
	input  wire logic [2:0]                            stack_index,
	output logic                                       busy,
	output logic                                       done,
	output logic signed [31:0]                         data,
	output sos_pkg::status_t                           status,
	output logic                                       all_empty,
	output logic [$clog2(NUM_STACKS)-1:0]              cnt_idx,
	input  wire logic [$clog2(STACK_DEPTH+1)-1:0]      cnt_rdata,
	output logic                                       cnt_we,
	output logic [$clog2(STACK_DEPTH+1)-1:0]           cnt_wdata,
	output logic                                       mem_we,
	output logic                                       mem_re,
	output logic [$clog2(NUM_STACKS)+$clog2(STACK_DEPTH)-1:0] mem_addr,
	output logic [DATA_WIDTH-1:0]                      mem_wdata,
	input  wire logic [DATA_WIDTH-1:0]                 mem_rdata
);
	import sos_pkg::*;

	localparam int IDX_W  = $clog2(NUM_STACKS);
	localparam int SLOT_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int TOT_W  = $clog2(NUM_STACKS * STACK_DEPTH + 1);

	state_t                       state_q, state_d;
	op_t                          op_q, op_d;
	logic signed [DATA_WIDTH-1:0] word_q, word_d;
	logic [IDX_W-1:0]             ptr_q, ptr_d;
	logic [IDX_W-1:0]             cur_q, cur_d;
	logic                         active_q, active_d;
	logic [TOT_W-1:0]             total_q, total_d;
	logic                         done_q, done_d;
	logic signed [31:0]           data_q, data_d;
	status_t                      status_q, status_d;

	// shared count unit
	logic             cnt_zero, cnt_full;
	logic [CNT_W-1:0] cnt_inc, cnt_dec, slot_cnt;
	logic signed [DATA_WIDTH-1:0] rd_word;
	op_t              op_in;

	assign cnt_zero = (cnt_rdata == '0);
	assign cnt_full = (cnt_rdata >= CNT_W'(STACK_DEPTH));
	assign cnt_inc  = cnt_rdata + CNT_W'(1);
	assign cnt_dec  = cnt_rdata - CNT_W'(1);
	assign slot_cnt = (op_q == OP_TOP) ? cnt_dec : cnt_rdata;
	assign rd_word  = mem_rdata;
	assign op_in    = op_t'(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			active_q <= 1'b0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cur_q    <= cur_d;
			active_q <= active_d;
			total_q  <= total_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		word_q   <= word_d;
		ptr_q    <= ptr_d;
		data_q   <= data_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		word_d    = word_q;
		ptr_d     = ptr_q;
		cur_d     = cur_q;
		active_d  = active_q;
		total_d   = total_q;
		done_d    = 1'b0;
		data_d    = data_q;
		status_d  = status_q;
		cnt_we    = 1'b0;
		cnt_wdata = cnt_rdata;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d     = op_in;
					word_d   = DATA_WIDTH'(value);
					data_d   = '0;
					status_d = STAT_OK;
					case (op_in)
						OP_PUSH: begin
							ptr_d   = active_q ? cur_q : '0;
							state_d = active_q ? S_PUSH_CUR : S_PUSH_CHK;
						end
						OP_POP, OP_TOP, OP_EMPTYQ: begin
							if (active_q) begin
								ptr_d   = cur_q;
								state_d = S_SCAN;
							end else begin
								cur_d    = '0;
								status_d = (op_in == OP_EMPTYQ) ? STAT_OK : STAT_EMPTY;
								done_d   = 1'b1;
							end
						end
						OP_POP_AT: begin
							if (32'(stack_index) >= 32'(NUM_STACKS)) begin
								status_d = STAT_EMPTY;
								done_d   = 1'b1;
							end else begin
								ptr_d   = IDX_W'(stack_index);
								state_d = S_PAT;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_PUSH_CUR, S_PUSH_CHK: begin
				if (cnt_full) begin
					// current one full: move on once, otherwise refuse
					if (state_q == S_PUSH_CUR && ptr_q != IDX_W'(NUM_STACKS - 1)) begin
						ptr_d   = ptr_q + IDX_W'(1);
						state_d = S_PUSH_CHK;
					end else begin
						status_d = STAT_FULL;
						done_d   = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					mem_we    = 1'b1;
					cnt_we    = 1'b1;
					cnt_wdata = cnt_inc;
					cur_d     = ptr_q;
					active_d  = 1'b1;
					total_d   = total_q + TOT_W'(1);
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!cnt_zero) begin
					cur_d = ptr_q;
					case (op_q)
						OP_POP: begin
							cnt_we    = 1'b1;
							cnt_wdata = cnt_dec;
							total_d   = total_q - TOT_W'(1);
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end
						OP_TOP: begin
							mem_re  = 1'b1;
							state_d = S_RDATA;
						end
						default: begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end
					endcase
				end else if (ptr_q == '0) begin
					active_d = 1'b0;
					cur_d    = '0;
					status_d = (op_q == OP_EMPTYQ) ? STAT_OK : STAT_EMPTY;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ptr_d = ptr_q - IDX_W'(1);
				end
			end
			S_RDATA: begin
				data_d  = 32'(rd_word);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_PAT: begin
				if (!cnt_zero) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_dec;
					total_d   = total_q - TOT_W'(1);
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end else if (ptr_q == '0) begin
					status_d = STAT_EMPTY;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ptr_d   = ptr_q - IDX_W'(1);
					state_d = S_PAT_LOW;
				end
			end
			S_PAT_LOW: begin
				if (!cnt_zero) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_dec;
					total_d   = total_q - TOT_W'(1);
				end else begin
					status_d = STAT_EMPTY;
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign data      = data_q;
	assign status    = status_q;
	assign all_empty = (total_q == '0);
	assign cnt_idx   = ptr_q;
	assign mem_addr  = {ptr_q, slot_cnt[SLOT_W-1:0]};
	assign mem_wdata = word_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("transfer taken but sequencer neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_inactive_cur: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (cur_q == '0))
		else $error("no active sub-stack but current index non-zero");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> !all_empty)
		else $error("full error reported on an empty store");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cnt_we && !mem_re))
		else $error("word write without count update");

endmodule

`default_nettype wire

// ===== hdl/set_of_stacks_engine_top.sv =====
// Top level of the set-of-stacks engine.
//
// A request is transferred when start is high and busy is low, and its result appears on
// data, status and all_empty for exactly one cycle with done high (busy is low in that
// cycle, so the next request may be transferred there). The receiver cannot stall results.
// Sequencer states after the transfer: a push writes in S_PUSH_CUR or S_PUSH_CHK, passing
// through both when it moves on to the next sub-stack; a pop at index decides in S_PAT, and
// in S_PAT_LOW as well when the named sub-stack is empty and one below it exists; pop, top
// and the empty query stay in S_SCAN while they walk back from the current sub-stack: the
// walk reads one entry count per cycle through the single port of the count file, and top
// then passes through S_RDATA for the registered word store read. Pop, top and the empty
// query with no active sub-stack, a pop at index beyond the stacks and the unused op codes
// are answered from idle and never raise busy; otherwise busy stays high until the cycle
// of done. No clearing pass runs after reset.
`default_nettype none

module set_of_stacks_engine_top #(
	parameter int NUM_STACKS  = 8,
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] value,
	input  wire logic [2:0]         stack_index,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      data,
	output logic [1:0]              status,
	output logic                    all_empty
);
	import sos_pkg::*;

	localparam int IDX_W  = $clog2(NUM_STACKS);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_STACKS) + $clog2(STACK_DEPTH);

	logic [IDX_W-1:0]      cnt_idx;
	logic [CNT_W-1:0]      cnt_rdata, cnt_wdata;
	logic                  cnt_we;
	logic                  mem_we, mem_re;
	logic [ADDR_W-1:0]     mem_addr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
	status_t               status_w;

	sos_ctrl #(
		.NUM_STACKS  (NUM_STACKS),
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.value       (value),
		.stack_index (stack_index),
		.busy        (busy),
		.done        (done),
		.data        (data),
		.status      (status_w),
		.all_empty   (all_empty),
		.cnt_idx     (cnt_idx),
		.cnt_rdata   (cnt_rdata),
		.cnt_we      (cnt_we),
		.cnt_wdata   (cnt_wdata),
		.mem_we      (mem_we),
		.mem_re      (mem_re),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	sos_cnt_file #(
		.NUM_STACKS  (NUM_STACKS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_cnt_file (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (cnt_idx),
		.rd_cnt (cnt_rdata),
		.we     (cnt_we),
		.wr_cnt (cnt_wdata)
	);

	sos_word_ram #(
		.ADDR_W     (ADDR_W),
		.DATA_WIDTH (DATA_WIDTH)
	) u_word_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign status = status_w;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the set-of-stacks engine: directed and random requests.
`timescale 1ns / 1ps

module tb;
	import sos_pkg::*;

	localparam int NUM_STACKS  = 8;
	localparam int STACK_DEPTH = 16;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 16;

	// op codes that the engine must ignore
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic signed [31:0] data;
		status_t            status;
		logic               all_empty;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         op = 3'd0;
	logic signed [31:0] value = '0;
	logic [2:0]         stack_index = 3'd0;
	logic               busy;
	logic               done;
	logic signed [31:0] data;
	logic [1:0]         status;
	logic               all_empty;

	// own copy of the engine state
	logic [31:0] word_store [NUM_STACKS * STACK_DEPTH];
	int          fill_level [NUM_STACKS] = '{default: 0};
	int          cur_stack = 0;
	bit          chain_live = 1'b0;

	result_t results_due [$];
	result_t due;
	int      fault_count = 0;
	bit      gaps_on = 1'b1;

	set_of_stacks_engine_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.value       (value),
		.stack_index (stack_index),
		.busy        (busy),
		.done        (done),
		.data        (data),
		.status      (status),
		.all_empty   (all_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk down to the highest sub-stack that holds an entry.
	function automatic bit settle_top();
		int s;
		if (chain_live) begin
			for (s = cur_stack; s >= 0; s--)
				if (fill_level[s] != 0) begin
					cur_stack = s;
					return 1'b1;
				end
		end
		chain_live = 1'b0;
		cur_stack = 0;
		return 1'b0;
	endfunction

	function automatic result_t apply_request(logic [2:0] opc, logic [31:0] word,
		logic [2:0] idx);
		result_t r;
		int      tgt;
		int      slot;
		r.data = '0;
		r.status = STAT_OK;
		case (opc)
			OP_PUSH: begin
				if (!chain_live)
					tgt = 0;
				else if (fill_level[cur_stack] >= STACK_DEPTH)
					tgt = cur_stack + 1;
				else
					tgt = cur_stack;
				if (tgt >= NUM_STACKS || fill_level[tgt] >= STACK_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					word_store[tgt * STACK_DEPTH + fill_level[tgt]] = word;
					fill_level[tgt]++;
					cur_stack = tgt;
					chain_live = 1'b1;
				end
			end
			OP_POP: begin
				if (settle_top())
					fill_level[cur_stack]--;
				else
					r.status = STAT_EMPTY;
			end
			OP_TOP: begin
				if (settle_top())
					r.data = word_store[cur_stack * STACK_DEPTH + fill_level[cur_stack] - 1];
				else
					r.status = STAT_EMPTY;
			end
			OP_POP_AT: begin
				slot = idx;
				if (slot >= NUM_STACKS) begin
					r.status = STAT_EMPTY;
				end else if (fill_level[slot] == 0 && (slot == 0 || fill_level[slot - 1] == 0)) begin
					r.status = STAT_EMPTY;
				end else begin
					// fall back to the sub-stack below when the named one is empty
					if (fill_level[slot] == 0)
						slot--;
					fill_level[slot]--;
				end
			end
			OP_EMPTYQ: void'(settle_top());
			default: ;
		endcase
		r.all_empty = 1'b1;
		foreach (fill_level[s])
			if (fill_level[s] != 0)
				r.all_empty = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("[%0t] %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				flag_fault($sformatf("unexpected result data=%h status=%0d all_empty=%b",
					data, status, all_empty));
			end else begin
				due = results_due.pop_front();
				if (data !== due.data || status !== due.status || all_empty !== due.all_empty)
					flag_fault($sformatf(
						"result mismatch: expected data=%h status=%0d all_empty=%b, got data=%h status=%0d all_empty=%b",
						due.data, due.status, due.all_empty, data, status, all_empty));
			end
		end
	end

	// Called at a rising edge; returns at the edge where the request is transferred.
	task automatic send_request(input logic [2:0] opc, input logic [31:0] word,
		input logic [2:0] idx);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= opc;
		value <= word;
		stack_index <= idx;
		do @(posedge clk); while (busy);
		results_due.push_back(apply_request(opc, word, idx));
	endtask

	task automatic send_op(input logic [2:0] opc);
		send_request(opc, rand_word(), 3'($urandom_range(0, 7)));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_store();
		send_op(OP_POP);
		send_op(OP_TOP);
		send_op(OP_EMPTYQ);
		send_request(OP_POP_AT, rand_word(), 3'd0);
		send_request(OP_POP_AT, rand_word(), 3'd7);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
			send_op(3'(c));
	endtask

	task automatic test_basic_ops();
		send_request(OP_PUSH, 32'h8000_0000, 3'd0);
		send_op(OP_TOP);
		send_request(OP_PUSH, 32'h7fff_ffff, 3'd7);
		send_op(OP_TOP);
		send_request(OP_PUSH, 32'h0000_0000, 3'd0);
		send_request(OP_PUSH, 32'hffff_ffff, 3'd5);
		send_op(OP_TOP);
		send_op(OP_POP);
		send_op(OP_TOP);
		send_request(OP_POP_AT, rand_word(), 3'd0);
		// named sub-stack empty, the one below still holds entries
		send_request(OP_POP_AT, rand_word(), 3'd1);
		send_op(OP_SPARE_FIRST);
		send_op(OP_POP);
		send_op(OP_POP);
		send_op(OP_EMPTYQ);
	endtask

	task automatic test_fill_to_full();
		gaps_on = 1'b0;
		// overfill so that the last pushes find the store full
		repeat (NUM_STACKS * STACK_DEPTH + 2)
			send_request(OP_PUSH, rand_word(), 3'($urandom_range(0, 7)));
		send_op(OP_TOP);
		send_request(OP_POP_AT, rand_word(), 3'd5);
		send_op(OP_PUSH);
		send_op(OP_POP);
		send_op(OP_TOP);
		send_op(OP_EMPTYQ);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_mix(input int count, input int push_pct, input bit with_gaps);
		logic [2:0] opc;
		logic [2:0] idx;
		int         pick;
		gaps_on = with_gaps;
		repeat (count) begin
			if ($urandom_range(0, 99) < push_pct) begin
				opc = OP_PUSH;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 6)
					opc = OP_POP;
				else if (pick < 10)
					opc = OP_TOP;
				else if (pick < 16)
					opc = OP_POP_AT;
				else if (pick < 19)
					opc = OP_EMPTYQ;
				else
					opc = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			end
			// aim pop-at near the live top half the time
			if ($urandom_range(0, 1))
				idx = 3'($urandom_range(0, 7));
			else
				idx = 3'(cur_stack + $urandom_range(0, 1));
			send_request(opc, rand_word(), idx);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_basic_ops();
		wait_drained();
		test_fill_to_full();
		test_random_mix(100, 30, 1'b1);
		test_random_mix(100, 10, 1'b0);
		test_random_mix(100, 85, 1'b1);
		test_random_mix(100, 90, 1'b1);
		wait_drained();
		test_random_mix(100, 50, 1'b0);
		test_random_mix(100, 20, 1'b1);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/sos_pkg.sv
hdl/sos_cnt_file.sv
hdl/sos_word_ram.sv
hdl/sos_ctrl.sv
hdl/set_of_stacks_engine_top.sv
tb/tb.sv
